>>> hdl/fsfd_pkg.sv
// Package: constants, item types and result types of the force sensor frame decoder.
`default_nettype none
package fsfd_pkg;

  localparam int FRAME_LENGTH     = 9;
  localparam int DATA_BYTES       = FRAME_LENGTH - 1;
  localparam int COUNT_W          = 4;
  localparam int RAW_FIRST        = 3;
  localparam int WINDOW_DEPTH_DEF = 3;
  localparam int OUT_DEPTH        = 4;

  localparam logic [31:0] RAW_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] SAT_NET    = 32'd999_500;
  localparam logic [19:0] ROUND_HALF = 20'd500;
  localparam logic [9:0]  UNITS_MAX  = 10'd999;
  // (s / 8) / 125 by reciprocal: exact for s below one million
  localparam logic [17:0] RECIP_M    = 18'd134_218;
  localparam int          RECIP_SH   = 24;

  typedef struct packed {
    logic        restart;
    logic        frame;
    logic        ok;
    logic [31:0] raw;
  } asm_item_t;

  typedef struct packed {
    logic        restart;
    logic        frame;
    logic        ok;
    logic [31:0] raw;
    logic [31:0] net;
    logic [1:0]  wcount;
    logic [31:0] oldest;
    logic [31:0] middle;
  } trk_item_t;

  typedef struct packed {
    logic        restart;
    logic        frame;
    logic        ok;
    logic [31:0] raw;
    logic [31:0] net;
    logic [1:0]  wcount;
    logic [31:0] oldest;
    logic [31:0] middle;
    logic        sat;
    logic [34:0] prod;
  } dsp_mid_t;

  typedef struct packed {
    logic        frame_ok;
    logic [31:0] raw_reading;
    logic [31:0] net_reading;
    logic [9:0]  display_units;
    logic        display_changed;
    logic [1:0]  window_count;
    logic [31:0] window_oldest;
    logic [31:0] window_middle;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/fsfd_if.sv
// Interfaces: input byte channel and result channel.
`default_nettype none
interface fsfd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_value;

  modport source (output valid, action, byte_value, input ready);
  modport sink (input valid, action, byte_value, output ready);
endinterface

interface fsfd_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [31:0] raw_reading;
  logic [31:0] net_reading;
  logic [9:0]  display_units;
  logic        display_changed;
  logic [1:0]  window_count;
  logic [31:0] window_oldest;
  logic [31:0] window_middle;

  modport source (output valid, frame_ok, raw_reading, net_reading, display_units,
                  display_changed, window_count, window_oldest, window_middle,
                  input ready);
  modport sink (input valid, frame_ok, raw_reading, net_reading, display_units,
                display_changed, window_count, window_oldest, window_middle,
                output ready);
endinterface
`default_nettype wire

>>> hdl/force_sensor_frame_decoder.sv
// Top level: force sensor frame decoder.
// Channels: in_ch takes one item per cycle while ready, either a sensor byte (action 0)
// or a session restart (action 1). out_ch gives one result for every ninth
// data byte: checksum flag, raw and net reading, rounded display figure with
// its change flag, window fill count, and the first two slots of the net reading window.
// Throughput: one input item per clock cycle while in_ch.ready is high.
// Path: a final byte passes the assembly register, the offset tracker, the rounding
// multiplier register and the queue before its result appears on out_ch.
// Results wait in a four-entry queue; in_ch.ready falls only while four
// results are outstanding, so a stalled receiver stops input after four
// frames and no result is lost.
// Restart clears the minimum reading and the display memory; the frame in
// assembly and the window are kept. Reset clears frame assembly, minimum,
// window fill, display memory and the queue; the block is ready at once.
`default_nettype none
module force_sensor_frame_decoder #(
  parameter int WINDOW_DEPTH = fsfd_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fsfd_in_if.sink     in_ch,
  fsfd_out_if.source  out_ch
);

  localparam int PCW = $clog2(fsfd_pkg::OUT_DEPTH + 1);

  logic                 in_acc;
  logic                 out_acc;
  logic                 is_final;
  logic [PCW-1:0]       pending_r, pending_nxt;
  fsfd_pkg::asm_item_t  asm_item;
  fsfd_pkg::trk_item_t  trk_item;
  logic                 res_push;
  fsfd_pkg::result_t    res_in;
  fsfd_pkg::result_t    res_out;
  logic                 res_valid;

  assign in_ch.ready = (pending_r < PCW'(fsfd_pkg::OUT_DEPTH));
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;

  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && is_final && !out_acc) begin
      pending_nxt = pending_r + 1'b1;
    end else if (!(in_acc && is_final) && out_acc) begin
      pending_nxt = pending_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  fsfd_assembler u_assembler (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .action     (in_ch.action),
    .byte_value (in_ch.byte_value),
    .item_r     (asm_item),
    .is_final   (is_final)
  );

  fsfd_tracker #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (asm_item),
    .item_r (trk_item)
  );

  fsfd_display u_display (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (trk_item),
    .push   (res_push),
    .result (res_in)
  );

  fsfd_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .wr_data  (res_in),
    .pop      (out_ch.ready),
    .rd_valid (res_valid),
    .rd_data  (res_out)
  );

  assign out_ch.valid           = res_valid;
  assign out_ch.frame_ok        = res_out.frame_ok;
  assign out_ch.raw_reading     = res_out.raw_reading;
  assign out_ch.net_reading     = res_out.net_reading;
  assign out_ch.display_units   = res_out.display_units;
  assign out_ch.display_changed = res_out.display_changed;
  assign out_ch.window_count    = res_out.window_count;
  assign out_ch.window_oldest   = res_out.window_oldest;
  assign out_ch.window_middle   = res_out.window_middle;

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= PCW'(fsfd_pkg::OUT_DEPTH))
    else $error("outstanding result count beyond queue depth");

  a_valid_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (pending_r != '0))
    else $error("result shown with no outstanding frame");

  a_units_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.display_units <= fsfd_pkg::UNITS_MAX))
    else $error("display figure beyond saturation limit");

endmodule
`default_nettype wire

>>> hdl/fsfd_assembler.sv
// Frame assembly: byte store, running XOR, checksum test and raw reading.
`default_nettype none
module fsfd_assembler (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               acc,
  input  wire logic               action,
  input  wire logic [7:0]         byte_value,
  output fsfd_pkg::asm_item_t     item_r,
  output logic                    is_final
);

  localparam int BIDX_W = $clog2(fsfd_pkg::DATA_BYTES);

  logic [fsfd_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [7:0]                   xor_r, xor_nxt;
  logic [7:0]                   bytes_r [fsfd_pkg::DATA_BYTES];
  fsfd_pkg::asm_item_t          item_nxt;

  assign is_final = !action &&
                    (count_r == fsfd_pkg::COUNT_W'(fsfd_pkg::DATA_BYTES));

  always_comb begin
    count_nxt    = count_r;
    xor_nxt      = xor_r;
    item_nxt     = '0;
    item_nxt.raw = {bytes_r[fsfd_pkg::RAW_FIRST],     bytes_r[fsfd_pkg::RAW_FIRST + 1],
                    bytes_r[fsfd_pkg::RAW_FIRST + 2], bytes_r[fsfd_pkg::RAW_FIRST + 3]};
    if (acc) begin
      if (action) begin
        item_nxt.restart = 1'b1;
      end else if (!is_final) begin
        count_nxt = count_r + 1'b1;
        xor_nxt   = xor_r ^ byte_value;
      end else begin
        count_nxt      = '0;
        xor_nxt        = '0;
        item_nxt.frame = 1'b1;
        item_nxt.ok    = (byte_value == xor_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      xor_r   <= '0;
      item_r  <= '0;
    end else begin
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
      item_r  <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !action && !is_final) begin
      bytes_r[count_r[BIDX_W-1:0]] <= byte_value;
    end
  end

endmodule
`default_nettype wire

>>> hdl/fsfd_tracker.sv
// Zero offset tracking and net reading window.
`default_nettype none
module fsfd_tracker #(
  parameter int WINDOW_DEPTH = fsfd_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fsfd_pkg::asm_item_t  item,
  output fsfd_pkg::trk_item_t       item_r
);

  localparam int FW      = $clog2(WINDOW_DEPTH + 1);
  localparam int MID_IDX = (WINDOW_DEPTH > 1) ? 1 : 0;

  logic [31:0]         small_r, small_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [31:0]         win_r   [WINDOW_DEPTH];
  logic [31:0]         win_nxt [WINDOW_DEPTH];
  logic [31:0]         new_small;
  logic [31:0]         net;
  logic                push;
  fsfd_pkg::trk_item_t item_nxt;

  assign new_small = (item.raw < small_r) ? item.raw : small_r;
  assign net       = item.raw - new_small;
  assign push      = item.frame && item.ok;

  always_comb begin
    small_nxt = small_r;
    fill_nxt  = fill_r;
    win_nxt   = win_r;
    if (item.restart) begin
      small_nxt = fsfd_pkg::RAW_ONES;
    end else if (push) begin
      small_nxt = new_small;
      if (32'(fill_r) >= WINDOW_DEPTH) begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[WINDOW_DEPTH - 1] = net;
      end else begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
          if (FW'(i) == fill_r) begin
            win_nxt[i] = net;
          end
        end
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_comb begin
    item_nxt         = '0;
    item_nxt.restart = item.restart;
    item_nxt.frame   = item.frame;
    item_nxt.ok      = item.ok;
    if (push) begin
      item_nxt.raw = item.raw;
      item_nxt.net = net;
    end
    if (32'(fill_nxt) > 3) begin
      item_nxt.wcount = 2'd3;
    end else begin
      item_nxt.wcount = 2'(fill_nxt);
    end
    if (fill_nxt != '0) begin
      item_nxt.oldest = win_nxt[0];
    end
    if (WINDOW_DEPTH > 1 && 32'(fill_nxt) > 1) begin
      item_nxt.middle = win_nxt[MID_IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_r <= fsfd_pkg::RAW_ONES;
      fill_r  <= '0;
      item_r  <= '0;
    end else begin
      small_r <= small_nxt;
      fill_r  <= fill_nxt;
      item_r  <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule
`default_nettype wire

>>> hdl/fsfd_display.sv
// Display rounding to thousands with saturation, and change detection.
`default_nettype none
module fsfd_display (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fsfd_pkg::trk_item_t  item,
  output logic                      push,
  output fsfd_pkg::result_t         result
);

  fsfd_pkg::dsp_mid_t mid_r, mid_nxt;
  logic [19:0]        sum;
  logic [9:0]         last_r, last_nxt;
  logic               shown_r, shown_nxt;
  logic [9:0]         units;
  logic               changed;
  logic               good;

  assign sum = item.net[19:0] + fsfd_pkg::ROUND_HALF;

  always_comb begin
    mid_nxt.restart = item.restart;
    mid_nxt.frame   = item.frame;
    mid_nxt.ok      = item.ok;
    mid_nxt.raw     = item.raw;
    mid_nxt.net     = item.net;
    mid_nxt.wcount  = item.wcount;
    mid_nxt.oldest  = item.oldest;
    mid_nxt.middle  = item.middle;
    mid_nxt.sat     = (item.net >= fsfd_pkg::SAT_NET);
    mid_nxt.prod    = 35'(sum[19:3]) * 35'(fsfd_pkg::RECIP_M);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= '0;
    end else begin
      mid_r <= mid_nxt;
    end
  end

  assign good    = mid_r.frame && mid_r.ok;
  assign units   = mid_r.sat ? fsfd_pkg::UNITS_MAX
                             : mid_r.prod[fsfd_pkg::RECIP_SH + 9:fsfd_pkg::RECIP_SH];
  assign changed = !shown_r || (units != last_r);

  always_comb begin
    last_nxt  = last_r;
    shown_nxt = shown_r;
    if (mid_r.restart) begin
      last_nxt  = '0;
      shown_nxt = 1'b0;
    end else if (good) begin
      last_nxt  = units;
      shown_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      shown_r <= 1'b0;
    end else begin
      last_r  <= last_nxt;
      shown_r <= shown_nxt;
    end
  end

  assign push                   = mid_r.frame;
  assign result.frame_ok        = mid_r.ok;
  assign result.raw_reading     = mid_r.raw;
  assign result.net_reading     = mid_r.net;
  assign result.display_units   = good ? units : '0;
  assign result.display_changed = good && changed;
  assign result.window_count    = mid_r.wcount;
  assign result.window_oldest   = mid_r.oldest;
  assign result.window_middle   = mid_r.middle;

endmodule
`default_nettype wire

>>> hdl/fsfd_out_fifo.sv
// Result queue between the display stage and the result channel.
`default_nettype none
module fsfd_out_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire fsfd_pkg::result_t  wr_data,
  input  wire logic               pop,
  output logic                    rd_valid,
  output fsfd_pkg::result_t       rd_data
);

  localparam int PW = $clog2(fsfd_pkg::OUT_DEPTH);
  localparam int CW = $clog2(fsfd_pkg::OUT_DEPTH + 1);

  fsfd_pkg::result_t mem_r [fsfd_pkg::OUT_DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_pop;

  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_pop   = pop && rd_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !do_pop && count_r == CW'(fsfd_pkg::OUT_DEPTH)))
    else $error("result queue written while full");

endmodule
`default_nettype wire

>>> tb/fsfd_checker.sv
// Checker: tracks the decoder's state, predicts each result and compares it with the output.
module fsfd_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  fsfd_in_if        in_mon,
  fsfd_out_if       out_mon,
  output int        fail_count,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WDEPTH = fsfd_pkg::WINDOW_DEPTH_DEF;

  logic [7:0]        frame_buf [fsfd_pkg::DATA_BYTES];
  logic [3:0]        bytes_held;
  logic [7:0]        xor_acc;
  logic [31:0]       min_raw;
  logic [31:0]       net_hist [WDEPTH];
  int unsigned       hist_fill;
  logic [9:0]        shown_units;
  logic              shown_any;
  fsfd_pkg::result_t due_results [$];

  function automatic logic [31:0] window_entry(input int k);
    if (k < WDEPTH && k < hist_fill) begin
      return net_hist[k];
    end
    return '0;
  endfunction

  task automatic decode_item(input logic act, input logic [7:0] b);
    fsfd_pkg::result_t r;
    logic [31:0]       raw;
    logic [31:0]       net;
    logic [32:0]       rounded;
    if (act) begin
      min_raw = fsfd_pkg::RAW_ONES;
      shown_units = '0;
      shown_any = 1'b0;
      return;
    end
    if (bytes_held < fsfd_pkg::DATA_BYTES) begin
      frame_buf[bytes_held[2:0]] = b;
      xor_acc ^= b;
      bytes_held++;
      return;
    end
    r = '0;
    r.frame_ok = (b == xor_acc);
    bytes_held = '0;
    xor_acc = '0;
    if (r.frame_ok) begin
      raw = {frame_buf[fsfd_pkg::RAW_FIRST], frame_buf[fsfd_pkg::RAW_FIRST + 1],
             frame_buf[fsfd_pkg::RAW_FIRST + 2], frame_buf[fsfd_pkg::RAW_FIRST + 3]};
      if (raw < min_raw) begin
        min_raw = raw;
      end
      net = raw - min_raw;
      if (hist_fill >= WDEPTH) begin
        for (int k = 0; k < WDEPTH - 1; k++) begin
          net_hist[k] = net_hist[k + 1];
        end
        net_hist[WDEPTH - 1] = net;
      end else begin
        net_hist[hist_fill] = net;
        hist_fill++;
      end
      rounded = ({1'b0, net} + 33'(fsfd_pkg::ROUND_HALF)) / 33'd1000;
      r.raw_reading = raw;
      r.net_reading = net;
      r.display_units = (rounded > 33'(fsfd_pkg::UNITS_MAX)) ? fsfd_pkg::UNITS_MAX
                                                             : rounded[9:0];
      r.display_changed = !shown_any || (r.display_units != shown_units);
      shown_units = r.display_units;
      shown_any = 1'b1;
    end
    r.window_count = (hist_fill > 3) ? 2'd3 : hist_fill[1:0];
    r.window_oldest = window_entry(0);
    r.window_middle = window_entry(1);
    due_results.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    fsfd_pkg::result_t want;
    if (!rst_n) begin
      bytes_held = '0;
      xor_acc = '0;
      min_raw = fsfd_pkg::RAW_ONES;
      hist_fill = 0;
      shown_units = '0;
      shown_any = 1'b0;
      due_results.delete();
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          $error("result with none due: raw_reading %0d", out_mon.raw_reading);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("frame_ok", want.frame_ok, out_mon.frame_ok);
          check_field("raw_reading", want.raw_reading, out_mon.raw_reading);
          check_field("net_reading", want.net_reading, out_mon.net_reading);
          check_field("display_units", want.display_units, out_mon.display_units);
          check_field("display_changed", want.display_changed, out_mon.display_changed);
          check_field("window_count", want.window_count, out_mon.window_count);
          check_field("window_oldest", want.window_oldest, out_mon.window_oldest);
          check_field("window_middle", want.window_middle, out_mon.window_middle);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        decode_item(in_mon.action, in_mon.byte_value);
      end
    end
    outstanding = due_results.size();
  end

endmodule

>>> tb/tb_force_sensor_frame_decoder.sv
// Testbench top: clock, reset, byte stream stimulus, result stalls, watchdog and verdict.
module tb_force_sensor_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET   = 1100;
  localparam int QUIET_TAIL    = 150;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 500;
  localparam int NO_RESTART    = -1;

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          outstanding;
  int          items_sent;
  int          data_pos;
  int          quiet_cycles;
  bit          tx_gaps;
  bit          rx_stalls;
  logic [31:0] session_floor;

  fsfd_in_if  in_ch ();
  fsfd_out_if out_ch ();

  force_sensor_frame_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fsfd_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && rx_stalls && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_ch.ready <= rst_n;
    end
  end

  task automatic send_item(input logic act, input logic [7:0] b);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.byte_value <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (!act) begin
      data_pos = (data_pos + 1) % fsfd_pkg::FRAME_LENGTH;
    end
  endtask

  task automatic send_sensor_frame(input logic [31:0] raw, input bit good,
                                   input int restart_at);
    logic [7:0] fb [fsfd_pkg::DATA_BYTES];
    logic [7:0] check;
    int         k;
    check = '0;
    for (k = 0; k < fsfd_pkg::DATA_BYTES; k++) begin
      fb[k] = 8'($urandom);
    end
    {fb[fsfd_pkg::RAW_FIRST], fb[fsfd_pkg::RAW_FIRST + 1], fb[fsfd_pkg::RAW_FIRST + 2],
     fb[fsfd_pkg::RAW_FIRST + 3]} = raw;
    for (k = 0; k < fsfd_pkg::DATA_BYTES; k++) begin
      check ^= fb[k];
    end
    if (!good) begin
      check ^= 8'($urandom_range(1, 255));
    end
    for (k = 0; k < fsfd_pkg::FRAME_LENGTH; k++) begin
      if (k == restart_at) begin
        send_item(1'b1, 8'($urandom));
      end
      send_item(1'b0, (k < fsfd_pkg::DATA_BYTES) ? fb[k] : check);
    end
  endtask

  function automatic logic [31:0] pick_reading();
    logic [31:0] base;
    base = (session_floor == fsfd_pkg::RAW_ONES) ? 32'($urandom_range(0, 50000))
                                                 : session_floor;
    case ($urandom_range(0, 9))
      0: return base;
      1, 2: return base + 32'($urandom_range(0, 3000));
      3: return base + 32'($urandom_range(0, 999)) * 1000 + 32'($urandom_range(499, 500));
      4: return base + 32'd999_000 + 32'($urandom_range(0, 1500));
      5: return base - 32'($urandom_range(1, 1000));
      6: return $urandom;
      7: return fsfd_pkg::RAW_ONES;
      default: return base + 32'($urandom_range(0, 2_000_000));
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] reading;
    bit          good;
    int          restart_at;
    int          pick;
    int          next_drain;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.byte_value = '0;
    items_sent = 0;
    data_pos = 0;
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    session_floor = fsfd_pkg::RAW_ONES;
    next_drain = ITEM_TARGET / 3;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_sensor_frame(fsfd_pkg::RAW_ONES, 1'b1, NO_RESTART);
    send_sensor_frame('0, 1'b0, 4);
    send_sensor_frame('0, 1'b1, NO_RESTART);
    session_floor = '0;

    tx_gaps = 1'b1;
    rx_stalls <= 1'b1;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET - QUIET_TAIL) begin
        tx_gaps = 1'b0;
        rx_stalls <= 1'b0;
      end else if ($urandom_range(0, 24) == 0) begin
        tx_gaps = 1'($urandom_range(0, 1));
        rx_stalls <= 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_item(1'b1, 8'($urandom));
        session_floor = fsfd_pkg::RAW_ONES;
      end else if (pick < 12) begin
        repeat ($urandom_range(1, 8)) send_item(1'b0, 8'($urandom));
      end else begin
        while (data_pos != 0) send_item(1'b0, 8'($urandom));
        reading = pick_reading();
        good = ($urandom_range(0, 9) != 0);
        restart_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8) : NO_RESTART;
        if (restart_at != NO_RESTART) begin
          session_floor = fsfd_pkg::RAW_ONES;
        end
        send_sensor_frame(reading, good, restart_at);
        if (good && reading < session_floor) begin
          session_floor = reading;
        end
      end
      if (items_sent >= next_drain) begin
        next_drain += ITEM_TARGET / 3;
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
      end
    end

    in_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/fsfd_pkg.sv
hdl/fsfd_if.sv
hdl/fsfd_assembler.sv
hdl/fsfd_tracker.sv
hdl/fsfd_display.sv
hdl/fsfd_out_fifo.sv
hdl/force_sensor_frame_decoder.sv
tb/fsfd_checker.sv
tb/tb_force_sensor_frame_decoder.sv
